// File: hw/rtl/bsm_pkg.sv
package bsm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 32;
  localparam int RAD_W = 31;
  localparam int DIFF_W = 33;
  localparam int SUMSQ_W = 67;
  localparam int ROOT_W = 34;
  localparam int NUM_W = 68;
  localparam int DIV_W = 36;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_POINT = 2'd1;
  localparam logic [1:0] MODE_SPHERE = 2'd2;

  localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

endpackage

// File: hw/rtl/bsm_divsqrt.sv
// shared restoring unit: square root (one result bit a cycle) or divide (one bit a cycle)
module bsm_divsqrt
  import bsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                is_sqrt,
  input  logic [NUM_W-1:0]    num,
  input  logic [DIV_W-1:0]    dvs,
  output logic                done,
  output logic [NUM_W-1:0]    quo
);

  logic [NUM_W-1:0]   n_r, n_nxt;
  logic [NUM_W-1:0]   q_r, q_nxt;
  logic [DIV_W+1:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]   dv_r, dv_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               sq_r, sq_nxt;
  logic               done_r, done_nxt;
  logic [DIV_W+1:0]   trial;
  logic [DIV_W+1:0]   sub;
  logic               ge;

  assign done = done_r;
  assign quo  = q_r;

  always_comb begin
    if (sq_r) begin
      trial = {rem_r[DIV_W-1:0], n_r[NUM_W-1 -: 2]};
      sub   = {q_r[DIV_W-1:0], 2'b01};
    end else begin
      trial = {rem_r[DIV_W:0], n_r[NUM_W-1]};
      sub   = {2'b00, dv_r};
    end
    ge = trial >= sub;
  end

  always_comb begin
    n_nxt = n_r; q_nxt = q_r; rem_nxt = rem_r; dv_nxt = dv_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; sq_nxt = sq_r; done_nxt = 1'b0;
    if (start) begin
      n_nxt = num; dv_nxt = dvs; sq_nxt = is_sqrt; q_nxt = '0; rem_nxt = '0;
      cnt_nxt = is_sqrt ? 7'(NUM_W/2) : 7'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = sq_r ? {n_r[NUM_W-3:0], 2'b00} : {n_r[NUM_W-2:0], 1'b0};
      rem_nxt = ge ? trial - sub : trial;
      q_nxt = {q_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r <= n_nxt; q_r <= q_nxt; rem_r <= rem_nxt; dv_r <= dv_nxt; sq_r <= sq_nxt;
  end

endmodule

// File: hw/rtl/bounding_sphere_merge_core.sv
// channel | ports                           | tdata / tuser fields (low bit up)
// in      | in_tvalid in_tready in_tdata    | in_x, in_y, in_z, in_radius (pad)
//         | in_tuser                        | mode
// out     | out_tvalid out_tready out_tdata | out_x, out_y, out_z, out_radius (pad)
//         | out_tuser                       | saturated
// load and unused mode: out_tvalid rises in the cycle after the accepting edge.
// point and sphere containment (either way): 3 square steps, a 34-step root, then decide.
// sphere union: the above plus three divides, one per axis, on the shared unit.
// one word in flight; in_tready is low from accept until the cycle after the result is taken.
// synchronous active-low reset clears the sphere to zero.
module bounding_sphere_merge_core
  import bsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // in_x, in_y, in_z, in_radius
  input  logic [1:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_x, out_y, out_z, out_radius
  output logic         out_tuser   // saturated
);

  localparam logic [3:0] ST_IDLE = 4'd0, ST_SQ = 4'd1, ST_ROOT = 4'd2,
    ST_WROOT = 4'd3, ST_DEC = 4'd4, ST_DIV = 4'd5, ST_WDIV = 4'd6, ST_OUT = 4'd7;

  logic [3:0] st_r, st_nxt;
  logic [1:0] mode_r;
  logic signed [COORD_W-1:0] c_r [3];
  logic signed [COORD_W-1:0] p_r [3];
  logic [RAD_W-1:0] r0_r, r1_r;
  logic sat_r;
  logic [1:0] ax_r;
  logic [SUMSQ_W-1:0] acc_r;
  logic [ROOT_W-1:0] d_r;
  logic signed [DIFF_W-1:0] dif;
  logic [DIFF_W-1:0] mg;
  logic [65:0] sq;
  logic u_start, u_sqrt, u_done;
  logic [NUM_W-1:0] u_num, u_quo;
  logic [DIV_W-1:0] u_dvs;
  logic [ROOT_W+1:0] big, kk;
  logic [DIFF_W-1:0] mgk;

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata  = {1'b0, r0_r, c_r[2], c_r[1], c_r[0]};
  assign out_tuser  = sat_r;

  assign dif = DIFF_W'(p_r[ax_r]) - DIFF_W'(c_r[ax_r]);
  assign mg  = dif[DIFF_W-1] ? DIFF_W'(-dif) : DIFF_W'(dif);
  assign sq  = mg * mg;
  assign big = ({2'b0, d_r} + 36'(r0_r) + 36'(r1_r)) >> 1;
  assign kk  = {2'b0, d_r} + 36'(r1_r) - 36'(r0_r);
  assign mgk = mg;

  bsm_divsqrt u_unit (
    .clk(clk), .rst_n(rst_n), .start(u_start), .is_sqrt(u_sqrt),
    .num(u_num), .dvs(u_dvs), .done(u_done), .quo(u_quo)
  );

  always_comb begin
    u_start = 1'b0; u_sqrt = 1'b0; u_num = '0; u_dvs = '0;
    if (st_r == ST_ROOT) begin
      u_start = 1'b1; u_sqrt = 1'b1; u_num = NUM_W'(acc_r);
    end else if (st_r == ST_DIV) begin
      u_start = 1'b1; u_num = NUM_W'(mgk * kk); u_dvs = {1'b0, d_r, 1'b0};
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_tvalid) st_nxt = (in_tuser == MODE_POINT || in_tuser == MODE_SPHERE)
                                        ? ST_SQ : ST_OUT;
      ST_SQ:    if (ax_r == 2'd2) st_nxt = ST_ROOT;
      ST_ROOT:  st_nxt = ST_WROOT;
      ST_WROOT: if (u_done) st_nxt = ST_DEC;
      ST_DEC:   st_nxt = ST_OUT;
      ST_DIV:   st_nxt = ST_WDIV;
      ST_WDIV:  if (u_done) st_nxt = (ax_r == 2'd2) ? ST_OUT : ST_DIV;
      ST_OUT:   if (out_tready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_DEC && mode_r == MODE_SPHERE &&
        !(36'(d_r) + 36'(r1_r) <= 36'(r0_r)) && !(36'(d_r) + 36'(r0_r) <= 36'(r1_r)))
      st_nxt = ST_DIV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      for (int i = 0; i < 3; i++) c_r[i] <= '0;
      r0_r <= '0;
      sat_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: if (in_tvalid) begin
          mode_r <= in_tuser;
          p_r[0] <= in_tdata[31:0];
          p_r[1] <= in_tdata[63:32];
          p_r[2] <= in_tdata[95:64];
          r1_r   <= in_tdata[126:96];
          sat_r  <= 1'b0;
          ax_r   <= 2'd0;
          acc_r  <= '0;
          if (in_tuser == MODE_LOAD) begin
            c_r[0] <= in_tdata[31:0];
            c_r[1] <= in_tdata[63:32];
            c_r[2] <= in_tdata[95:64];
            r0_r   <= in_tdata[126:96];
          end
        end
        ST_SQ: begin
          acc_r <= acc_r + SUMSQ_W'(sq);
          ax_r  <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
        ST_WROOT: if (u_done) d_r <= u_quo[ROOT_W-1:0];
        ST_DEC: begin
          if (mode_r == MODE_POINT) begin
            if (35'(d_r) > 35'(r0_r)) begin
              if (d_r > 34'(RAD_MAX)) begin
                r0_r <= RAD_MAX; sat_r <= 1'b1;
              end else r0_r <= d_r[RAD_W-1:0];
            end
          end else if (36'(d_r) + 36'(r1_r) <= 36'(r0_r)) begin
          end else if (36'(d_r) + 36'(r0_r) <= 36'(r1_r)) begin
            c_r[0] <= p_r[0]; c_r[1] <= p_r[1]; c_r[2] <= p_r[2]; r0_r <= r1_r;
          end
        end
        ST_WDIV: if (u_done) begin
          c_r[ax_r] <= dif[DIFF_W-1] ? c_r[ax_r] - COORD_W'(u_quo)
                                     : c_r[ax_r] + COORD_W'(u_quo);
          ax_r <= ax_r + 2'd1;
          if (ax_r == 2'd2) begin
            if (big > 36'(RAD_MAX)) begin
              r0_r <= RAD_MAX; sat_r <= 1'b1;
            end else r0_r <= big[RAD_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: dv/bounding_sphere_merge_checker.sv
module bounding_sphere_merge_checker
  import bsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,   // in_x, in_y, in_z, in_radius
  input  logic [1:0]   in_tuser,   // mode
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,  // out_x, out_y, out_z, out_radius
  input  logic         out_tuser,  // saturated
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [RAD_W-1:0]   radius;
    logic               sat;
  } sphere_word_t;

  sphere_word_t expected_spheres[$];

  logic signed [63:0] cen_x, cen_y, cen_z;
  logic [127:0]       cur_rad;

  localparam logic [127:0] RMAX_W = 128'(RAD_MAX);

  function automatic logic [127:0] magnitude(logic signed [63:0] v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [127:0] dist_floor(logic signed [63:0] dx, logic signed [63:0] dy,
                                              logic signed [63:0] dz);
    logic [127:0] ax, ay, az, s, r, c;
    ax = magnitude(dx);
    ay = magnitude(dy);
    az = magnitude(dz);
    s = ax * ax + ay * ay + az * az;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] move_centre(logic signed [63:0] c0,
      logic signed [63:0] dlt, logic [127:0] k, logic [127:0] twod);
    logic [127:0] m;
    m = (magnitude(dlt) * k) / twod;
    return (dlt < 0) ? c0 - $signed({1'b0, m[62:0]}) : c0 + $signed({1'b0, m[62:0]});
  endfunction

  function automatic sphere_word_t predict_sphere(logic [1:0] mode, logic [127:0] d_in);
    logic signed [63:0] px, py, pz, dx, dy, dz;
    logic [127:0] r1, r0, d, big;
    sphere_word_t w;
    px = 64'(signed'(d_in[31:0]));
    py = 64'(signed'(d_in[63:32]));
    pz = 64'(signed'(d_in[95:64]));
    r1 = 128'(d_in[126:96]);
    w.sat = 1'b0;
    dx = px - cen_x;
    dy = py - cen_y;
    dz = pz - cen_z;
    case (mode)
      MODE_LOAD: begin
        cen_x = px; cen_y = py; cen_z = pz; cur_rad = r1;
      end
      MODE_POINT: begin
        d = dist_floor(dx, dy, dz);
        if (d > cur_rad) begin
          if (d > RMAX_W) begin
            d = RMAX_W;
            w.sat = 1'b1;
          end
          cur_rad = d;
        end
      end
      MODE_SPHERE: begin
        d = dist_floor(dx, dy, dz);
        r0 = cur_rad;
        if (d + r1 <= r0) begin
          // stored sphere already holds the incoming one
        end else if (d + r0 <= r1) begin
          cen_x = px; cen_y = py; cen_z = pz; cur_rad = r1;
        end else begin
          big = (d + r0 + r1) >> 1;
          cen_x = move_centre(cen_x, dx, d + r1 - r0, d << 1);
          cen_y = move_centre(cen_y, dy, d + r1 - r0, d << 1);
          cen_z = move_centre(cen_z, dz, d + r1 - r0, d << 1);
          if (big > RMAX_W) begin
            big = RMAX_W;
            w.sat = 1'b1;
          end
          cur_rad = big;
        end
      end
      default: ;
    endcase
    w.x = cen_x[31:0];
    w.y = cen_y[31:0];
    w.z = cen_z[31:0];
    w.radius = cur_rad[RAD_W-1:0];
    return w;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    cen_x = '0; cen_y = '0; cen_z = '0; cur_rad = '0;
  end

  always @(posedge clk) begin
    sphere_word_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_spheres.push_back(predict_sphere(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[31:0];
        got.y = out_tdata[63:32];
        got.z = out_tdata[95:64];
        got.radius = out_tdata[126:96];
        got.sat = out_tuser;
        if (expected_spheres.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %h", got);
        end else begin
          want = expected_spheres.pop_front();
          if (got !== want || out_tdata[127] !== 1'b0) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: x %h/%h y %h/%h z %h/%h r %h/%h sat %b/%b (exp/got)",
                       want.x, got.x, want.y, got.y, want.z, got.z,
                       want.radius, got.radius, want.sat, got.sat);
          end
        end
      end
      pending <= expected_spheres.size();
    end
  end

  final begin
    if (expected_spheres.size() != 0) $display("words still expected: %0d", expected_spheres.size());
  end
endmodule

// File: dv/bounding_sphere_merge_core_tb.sv
module bounding_sphere_merge_core_tb;
  import bsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WATCH_LIMIT = 20000;
  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam logic [31:0] CMIN = 32'h8000_0000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // in_x, in_y, in_z, in_radius
  logic [1:0]   in_tuser = '0;   // mode
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // out_x, out_y, out_z, out_radius
  logic         out_tuser;       // saturated
  int           errors, pending;
  int           send_idle = 29, recv_idle = 48;
  bit           hold_req = 0;
  int           hold_left = 0;
  int           quiet = 0;

  bounding_sphere_merge_core dut (.*);

  bounding_sphere_merge_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .errors, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 2000;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCH_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] mode, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [30:0] r);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {1'b0, r, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'(signed'(20'($urandom())));
      default: return 32'(signed'(24'($urandom())));
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 15));
      default: return 31'($urandom_range(0, 32'h00ff_ffff));
    endcase
  endfunction

  task automatic random_phase(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) send_word(MODE_LOAD, rand_coord(), rand_coord(), rand_coord(), rand_radius());
      else if (pick < 45) send_word(MODE_POINT, rand_coord(), rand_coord(), rand_coord(),
                                    31'($urandom()));
      else if (pick < 95) send_word(MODE_SPHERE, rand_coord(), rand_coord(), rand_coord(),
                                    rand_radius());
      else send_word(MODE_UNUSED, $urandom(), $urandom(), $urandom(), 31'($urandom()));
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, point saturation, containment both ways, unions
    send_word(MODE_POINT, 32'd100, 32'd0, 32'd0, 31'd0);
    send_word(MODE_LOAD, CMAX, CMAX, CMAX, RAD_MAX);
    send_word(MODE_POINT, CMAX, CMAX, CMAX, 31'd5);
    send_word(MODE_LOAD, CMIN, CMIN, CMIN, 31'd0);
    send_word(MODE_POINT, CMAX, CMAX, CMAX, 31'd0);
    send_word(MODE_LOAD, 32'd0, 32'd0, 32'd0, 31'd1000);
    send_word(MODE_SPHERE, 32'd10, 32'd0, 32'd0, 31'd5);
    send_word(MODE_SPHERE, 32'd0, 32'd0, 32'd0, 31'd1000);
    send_word(MODE_SPHERE, 32'd0, 32'd0, 32'd0, 31'd2000);
    send_word(MODE_SPHERE, -32'sd30, 32'd40, 32'd0, 31'd100000);
    send_word(MODE_SPHERE, 32'h0010_0000, -32'sd7, 32'd3, 31'd500);
    send_word(MODE_POINT, -32'sd70000, 32'd5, -32'sd9, 31'd0);
    send_word(MODE_SPHERE, CMIN, 32'd0, CMAX, 31'd77);
    send_word(MODE_UNUSED, CMAX, CMIN, CMAX, RAD_MAX);
    send_word(MODE_LOAD, CMIN, 32'd0, 32'd0, RAD_MAX);
    send_word(MODE_SPHERE, CMAX, 32'd0, 32'd0, RAD_MAX);
    send_word(MODE_LOAD, CMAX, CMIN, 32'd1, 31'd1);
    send_word(MODE_SPHERE, CMIN, CMAX, -32'sd1, 31'd1);
    send_word(MODE_SPHERE, 32'd0, 32'd0, 32'd0, 31'd0);
    in_tvalid <= 1'b0;
    @(posedge clk);

    hold_req = 1;
    random_phase(560);
    wait (pending == 0);
    repeat (300) @(posedge clk);
    send_idle = 48;
    recv_idle = 29;
    random_phase(560);
    wait (pending == 0);
    send_idle = 0;
    recv_idle = 0;
    random_phase(560);

    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
